/* sv/rgb_conv3x3_sobel_clamp_top_macros.svh */
// Assertion helpers for the Sobel block.
`ifndef RGB_CONV3X3_SOBEL_CLAMP_TOP_MACROS_SVH
`define RGB_CONV3X3_SOBEL_CLAMP_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_AFTER3(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rst, cond)
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_AFTER3(name, clk, rst, ante, cons)
`endif
`endif

/* sv/rcs_pkg.sv */
`timescale 1ns / 1ps

package rcs_pkg;

   typedef struct packed {
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  blue_out;
      logic [7:0]  green_out;
      logic [7:0]  red_out;
      logic [11:0] out_row;
      logic [10:0] out_col;
      logic        frame_last;
   } rsp_type;

   typedef struct packed {
      logic [11:0] out_row;
      logic [10:0] out_col;
      logic        frame_last;
   } meta_type;

   localparam int OQ_DEPTH = 8;
   localparam int OQ_PTR_W = 3;
   localparam int OQ_LVL_W = 4;

   typedef struct packed {
      logic                full;
      logic [OQ_LVL_W-1:0] level;
   } oq_status_type;

   localparam int PIX_W = 24;
   localparam int CH_W  = 8;

   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;
   localparam int          MIN_DIM      = 3;
   localparam logic [12:0] MAX_HEIGHT   = 13'd4096;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

endpackage

/* sv/rcs_linebuf.sv */
`timescale 1ns / 1ps

module rcs_linebuf #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [rcs_pkg::PIX_W-1:0]  wr_pix,
   output logic [rcs_pkg::PIX_W-1:0]  rd_upper
);

   logic [rcs_pkg::PIX_W-1:0] upper_mem [DEPTH];
   logic [rcs_pkg::PIX_W-1:0] middle_mem [DEPTH];
   logic [rcs_pkg::PIX_W-1:0] rd_upper_ff;
   logic [rcs_pkg::PIX_W-1:0] rd_middle_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_upper_ff  <= upper_mem[rd_addr];
         rd_middle_ff <= middle_mem[rd_addr];
      end
   end

   // the row moves down: old middle becomes upper, new pixel becomes middle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= rd_middle_ff;
         middle_mem[wr_addr] <= wr_pix;
      end
   end

   assign rd_upper = rd_upper_ff;

endmodule

/* sv/rcs_lane.sv */
`timescale 1ns / 1ps

module rcs_lane (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [2:0][rcs_pkg::CH_W-1:0]   top_row,
   input  logic [2:0][rcs_pkg::CH_W-1:0]   bot_row,
   output logic                            out_valid,
   output logic [rcs_pkg::CH_W-1:0]        out_value
);

   logic [9:0]              pos_sum;
   logic [9:0]              neg_sum;
   logic [10:0]             diff;
   logic [rcs_pkg::CH_W-1:0] clamp_val;
   logic                    valid_ff;
   logic [rcs_pkg::CH_W-1:0] value_ff;

   always_comb begin
      pos_sum = {2'b00, bot_row[0]} + {1'b0, bot_row[1], 1'b0} + {2'b00, bot_row[2]};
      neg_sum = {2'b00, top_row[0]} + {1'b0, top_row[1], 1'b0} + {2'b00, top_row[2]};
      diff    = {1'b0, pos_sum} - {1'b0, neg_sum};
      if (diff[10]) begin
         clamp_val = '0;
      end else if (diff[9:8] != 2'b00) begin
         clamp_val = '1;
      end else begin
         clamp_val = diff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= clamp_val;
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;

endmodule

/* sv/rcs_outq.sv */
`timescale 1ns / 1ps

module rcs_outq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [rcs_pkg::CH_W-1:0]   blue,
   input  logic [rcs_pkg::CH_W-1:0]   green,
   input  logic [rcs_pkg::CH_W-1:0]   red,
   input  rcs_pkg::meta_type          meta,
   input  logic [1:0]                 pipe_count,
   output rcs_pkg::oq_status_type     status,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rcs_pkg::rsp_type           rsp_data
);

   rcs_pkg::rsp_type               entry_ff [rcs_pkg::OQ_DEPTH];
   rcs_pkg::rsp_type               merged;
   logic [rcs_pkg::OQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rcs_pkg::OQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rcs_pkg::OQ_LVL_W-1:0]   level_ff, level_in;
   logic [rcs_pkg::OQ_LVL_W-1:0]   committed;
   logic                           pop;

   // merge the three channel lanes with the position tags
   always_comb begin
      merged.blue_out   = blue;
      merged.green_out  = green;
      merged.red_out    = red;
      merged.out_row    = meta.out_row;
      merged.out_col    = meta.out_col;
      merged.frame_last = meta.frame_last;
   end

   assign pop       = (level_ff != '0) && !rsp_stall;
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign level_in  = level_ff + {{(rcs_pkg::OQ_LVL_W-1){1'b0}}, push}
                               - {{(rcs_pkg::OQ_LVL_W-1){1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= merged;
      end
   end

   // items still in the pipe already own a slot
   assign committed   = level_ff + {{(rcs_pkg::OQ_LVL_W-2){1'b0}}, pipe_count};
   assign status.full  = committed >= rcs_pkg::OQ_LVL_W'(rcs_pkg::OQ_DEPTH);
   assign status.level = level_ff;

   assign rsp_valid = level_ff != '0;
   assign rsp_data  = entry_ff[rd_ptr_ff];

endmodule

/* sv/rgb_conv3x3_sobel_clamp_top.sv */
`timescale 1ns / 1ps
// Vertical Sobel (-1 -2 -1 / 0 0 0 / 1 2 1) over an RGB raster stream, each channel
// clamped to 0..255. One pixel is taken per clock, back to back, while req_stall is low;
// border pixels give no result. Each interior result is started when the pixel below-right
// of it is taken, passes line buffer read, window shift, lane register and output queue
// write, and is offered on rsp tagged with its row, column and an end-of-frame mark. Two
// line buffers of MAX_WIDTH x 24 bits (one read and one write port each) hold the previous
// rows; they are not cleared, so no result is emitted while the first two rows of a frame
// are taken. The output queue holds 8 results, and req_stall rises when queue plus pipeline
// reach that count. Registers: frame_width at 0x0, frame_height at 0x4, out-of-range values
// clamp to 3..MAX_WIDTH and 3..4096; write them only between frames while the block is idle.
`include "rgb_conv3x3_sobel_clamp_top_macros.svh"

module rgb_conv3x3_sobel_clamp_top #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rcs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rcs_pkg::rsp_type  rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int EW = (AW + 1 > 12) ? AW + 1 : 12;

   // configuration
   logic [11:0]  width_ff;
   logic [12:0]  height_ff;
   logic         csr_wr;
   logic [EW-1:0] eff_w;
   logic [EW-1:0] width_ext;
   logic [12:0]  eff_h;

   // position counters
   logic [AW-1:0] col_ff, col_in;
   logic [11:0]   row_ff, row_in;
   logic [EW-1:0] col_plus;
   logic [12:0]   row_plus;
   logic          col_wrap, row_wrap;
   logic          emit_now;
   logic          accept;
   rcs_pkg::meta_type meta_now;

   // pipeline
   logic                       s1_valid_ff;
   logic                       s1_emit_ff;
   logic [AW-1:0]              s1_addr_ff;
   logic [rcs_pkg::PIX_W-1:0]  s1_pix_ff;
   rcs_pkg::meta_type          s1_meta_ff;
   logic                       s2_valid_ff;
   rcs_pkg::meta_type          s2_meta_ff;
   rcs_pkg::meta_type          s3_meta_ff;
   logic [rcs_pkg::PIX_W-1:0]  rd_upper;
   logic [2:0][rcs_pkg::PIX_W-1:0] win_top_ff, win_bot_ff;

   logic [2:0]                 lane_valid;
   logic [2:0][rcs_pkg::CH_W-1:0] lane_value;
   logic [1:0]                 pipe_count;
   rcs_pkg::oq_status_type     oq_status;
   logic [rcs_pkg::OQ_LVL_W:0] in_flight;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rcs_pkg::WIDTH_RESET;
         height_ff <= rcs_pkg::HEIGHT_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == rcs_pkg::REG_FRAME_WIDTH) begin
            width_ff <= csr_pwdata[11:0];
         end else begin
            height_ff <= csr_pwdata[12:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == rcs_pkg::REG_FRAME_HEIGHT) ?
                       {19'd0, height_ff} : {20'd0, width_ff};

   assign width_ext = EW'(width_ff);

   always_comb begin
      if (width_ext < EW'(rcs_pkg::MIN_DIM)) begin
         eff_w = EW'(rcs_pkg::MIN_DIM);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = width_ext;
      end
      if (height_ff < 13'(rcs_pkg::MIN_DIM)) begin
         eff_h = 13'(rcs_pkg::MIN_DIM);
      end else if (height_ff > rcs_pkg::MAX_HEIGHT) begin
         eff_h = rcs_pkg::MAX_HEIGHT;
      end else begin
         eff_h = height_ff;
      end
   end

   // ---------------- raster position ----------------
   assign req_stall = oq_status.full;
   assign accept    = req_valid && !req_stall;
   assign col_plus  = EW'(col_ff) + EW'(1);
   assign row_plus  = 13'(row_ff) + 13'd1;
   assign col_wrap  = col_plus >= eff_w;
   assign row_wrap  = row_plus >= eff_h;
   assign emit_now  = (row_ff >= 12'd2) && (col_ff >= AW'(2));

   always_comb begin
      meta_now.out_row    = row_ff - 12'd1;
      meta_now.out_col    = 11'(col_ff - AW'(1));
      meta_now.frame_last = row_wrap && col_wrap;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? 12'd0 : row_plus[11:0];
         end else begin
            col_in = col_plus[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- stage 1: line buffer read ----------------
   rcs_linebuf #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_linebuf (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (col_ff),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_addr_ff),
      .wr_pix    (s1_pix_ff),
      .rd_upper  (rd_upper)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= emit_now;
         s1_addr_ff <= col_ff;
         s1_pix_ff  <= {req_data.red_in, req_data.green_in, req_data.blue_in};
         s1_meta_ff <= meta_now;
      end
      // stage 2: window shift; the middle row carries zero weight and is not kept
      if (s1_valid_ff) begin
         win_top_ff <= {rd_upper, win_top_ff[2:1]};
         win_bot_ff <= {s1_pix_ff, win_bot_ff[2:1]};
         s2_meta_ff <= s1_meta_ff;
      end
      s3_meta_ff <= s2_meta_ff;
   end

   // ---------------- stage 3: one lane per color channel ----------------
   for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [2:0][rcs_pkg::CH_W-1:0] top_ch;
      logic [2:0][rcs_pkg::CH_W-1:0] bot_ch;

      always_comb begin
         for (int j = 0; j < 3; j++) begin
            top_ch[j] = win_top_ff[j][rcs_pkg::CH_W*k +: rcs_pkg::CH_W];
            bot_ch[j] = win_bot_ff[j][rcs_pkg::CH_W*k +: rcs_pkg::CH_W];
         end
      end

      rcs_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (s2_valid_ff),
         .top_row   (top_ch),
         .bot_row   (bot_ch),
         .out_valid (lane_valid[k]),
         .out_value (lane_value[k])
      );
   end

   // ---------------- merge and output queue ----------------
   assign pipe_count = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff} + {1'b0, lane_valid[0]};

   rcs_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (lane_valid[0]),
      .blue       (lane_value[0]),
      .green      (lane_value[1]),
      .red        (lane_value[2]),
      .meta       (s3_meta_ff),
      .pipe_count (pipe_count),
      .status     (oq_status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign in_flight = {1'b0, oq_status.level} + (rcs_pkg::OQ_LVL_W+1)'(pipe_count);

   // ---------------- checks ----------------
   `ASSERT_ALWAYS(a_credit_bound, clock, reset, in_flight <= (rcs_pkg::OQ_LVL_W+1)'(rcs_pkg::OQ_DEPTH))
   `ASSERT_AFTER3(a_interior_emits, clock, reset, accept && emit_now, lane_valid[0])
   `ASSERT_IMPLY(a_no_border, clock, reset, rsp_valid, (rsp_data.out_row != 12'd0) && (rsp_data.out_col != 11'd0))
   `ASSERT_ALWAYS(a_lanes_aligned, clock, reset, (lane_valid == 3'b000) || (lane_valid == 3'b111))

endmodule
